// File: rtl/assert_macros.svh
// Assertion macros for the deframer RTL.
// Depends on nothing; included by shdf_engine.sv, which carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define SHDF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Check that cond never holds outside reset.
`define SHDF_ASSERT_NEVER(label, clk, rst, cond) \
   `SHDF_ASSERT(label, clk, rst, !(cond))

`endif

// File: rtl/shdf_pkg.sv
// Package for the sync-header frame deframer: constants, codes and structs.
// Depends on nothing; used by every other deframer file but assert_macros.svh.
package shdf_pkg;

   localparam int BYTE_W       = 8;
   localparam int HALF_W       = 16;
   localparam int WORD_W       = 32;
   localparam int HDR_STORE_W  = 64;
   localparam int POS_W        = 17;
   localparam int STATUS_W     = 3;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int TAIL_CNT_W   = 2;

   localparam int HDR_LEN      = 12;
   localparam int LEN_POS      = 10;
   localparam int TRAILER_BASE = 14;
   localparam int CHECK_EXTRA  = 2;
   localparam int CHECK_BIT    = 7;
   localparam int CIPHER_MSB   = 5;
   localparam int CIPHER_LSB   = 4;
   localparam logic [1:0] CIPHER_XOR = 2'b01;

   localparam logic [BYTE_W-1:0]     SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0]     SYNC_SECOND_RESET = 8'h55;
   localparam logic [BYTE_W-1:0]     KEY_RESET         = 8'h5A;
   localparam logic [CSR_DATA_W-1:0] LIMIT_RESET       = 16'd1500;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_HUNT_FIRST  = 3'd0,
      PH_HUNT_SECOND = 3'd1,
      PH_HEADER      = 3'd2,
      PH_PAYLOAD     = 3'd3,
      PH_TAIL        = 3'd4
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HEADER   = 3'd0,
      ST_PAYLOAD  = 3'd1,
      ST_TAIL     = 3'd2,
      ST_ACCEPTED = 3'd3,
      ST_BAD_SYNC = 3'd4,
      ST_OVERSIZE = 3'd5,
      ST_MISMATCH = 3'd6
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_FIRST   = 2'd0,
      CSR_SYNC_SECOND  = 2'd1,
      CSR_SCRAMBLE_KEY = 2'd2,
      CSR_FRAME_LIMIT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
      logic [BYTE_W-1:0] scramble_key;
      logic [HALF_W-1:0] frame_limit;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              first_hit;
      logic              second_hit;
      logic [BYTE_W-1:0] descrambled;
   } queue_entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   payload_byte;
      logic [BYTE_W-1:0]   version;
      logic [BYTE_W-1:0]   frame_control;
      logic [HALF_W-1:0]   sequence_number;
      logic [WORD_W-1:0]   time_stamp;
      logic [HALF_W-1:0]   payload_length;
      logic [HALF_W-1:0]   frame_length;
      logic [HALF_W-1:0]   received_check;
      logic [HALF_W-1:0]   computed_check;
   } result_type;

endpackage

// File: rtl/shdf_req_if.sv
// Byte input channel: valid/ready handshake carrying one received byte.
// Depends on shdf_pkg.
interface shdf_req_if;
   import shdf_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/shdf_rsp_if.sv
// Result channel: valid/ready handshake carrying status and frame fields.
// Depends on shdf_pkg.
interface shdf_rsp_if;
   import shdf_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   payload_byte;
   logic [BYTE_W-1:0]   version;
   logic [BYTE_W-1:0]   frame_control;
   logic [HALF_W-1:0]   sequence_number;
   logic [WORD_W-1:0]   time_stamp;
   logic [HALF_W-1:0]   payload_length;
   logic [HALF_W-1:0]   frame_length;
   logic [HALF_W-1:0]   received_check;
   logic [HALF_W-1:0]   computed_check;

   modport source (
      output valid, output status, output payload_byte, output version,
      output frame_control, output sequence_number, output time_stamp,
      output payload_length, output frame_length, output received_check,
      output computed_check, input ready
   );
   modport sink (
      input valid, input status, input payload_byte, input version,
      input frame_control, input sequence_number, input time_stamp,
      input payload_length, input frame_length, input received_check,
      input computed_check, output ready
   );
endinterface

// File: rtl/sync_header_frame_deframer.sv
// Top level of the sync-header frame deframer: configuration registers,
// front end, queue and frame engine. Depends on shdf_pkg and both channel interfaces.
//
//   port       dir  handshake            carries
//   req_chan   in   valid / ready        rx_byte
//   rsp_chan   out  valid / ready        status, payload_byte, header fields, checks
//   csr_*      in   csr_write_en strobe  csr_index, csr_write_data
//
// One byte per cycle sustained while rsp_chan does not stall; each byte gives one
// transaction on rsp_chan. Each byte is registered in the queue and then in the
// engine's result register. The rate is set by the engine's per-byte state update.
// Synchronous reset clears phase, queue pointers and result valid; no clearing pass.
// A stall on rsp_chan holds the result register; the two-entry queue absorbs
// up to two transactions before req_chan.ready drops.
module sync_header_frame_deframer (
   input  logic                                  clock,
   input  logic                                  reset,
   shdf_req_if.sink                              req_chan,
   shdf_rsp_if.source                            rsp_chan,
   input  logic                                  csr_write_en,
   input  logic [shdf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [shdf_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import shdf_pkg::*;

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   logic              push;
   queue_entry_type   push_entry;
   logic              full;
   logic              pop;
   logic              empty;
   queue_entry_type   head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SYNC_FIRST:   cfg_in.sync_first   = csr_write_data[BYTE_W-1:0];
            CSR_SYNC_SECOND:  cfg_in.sync_second  = csr_write_data[BYTE_W-1:0];
            CSR_SCRAMBLE_KEY: cfg_in.scramble_key = csr_write_data[BYTE_W-1:0];
            CSR_FRAME_LIMIT:  cfg_in.frame_limit  = csr_write_data[HALF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first   <= SYNC_FIRST_RESET;
         cfg_ff.sync_second  <= SYNC_SECOND_RESET;
         cfg_ff.scramble_key <= KEY_RESET;
         cfg_ff.frame_limit  <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   shdf_front u_front (
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .full       (full),
      .push       (push),
      .push_entry (push_entry)
   );

   shdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .empty      (empty),
      .head       (head)
   );

   shdf_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .empty    (empty),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );
endmodule

// File: rtl/shdf_front.sv
// Front end: accepts received bytes and tags them with sync matches and
// the descrambled value. Depends on shdf_pkg and shdf_req_if.
module shdf_front (
   shdf_req_if.sink                   req_chan,
   input  shdf_pkg::cfg_type          cfg,
   input  logic                       full,
   output logic                       push,
   output shdf_pkg::queue_entry_type  push_entry
);
   import shdf_pkg::*;

   assign req_chan.ready = !full;
   assign push           = req_chan.valid && !full;

   always_comb begin
      push_entry.rx_byte     = req_chan.rx_byte;
      push_entry.first_hit   = (req_chan.rx_byte == cfg.sync_first);
      push_entry.second_hit  = (req_chan.rx_byte == cfg.sync_second);
      push_entry.descrambled = req_chan.rx_byte ^ cfg.scramble_key;
   end
endmodule

// File: rtl/shdf_queue.sv
// Short queue between front end and frame engine.
// Depends on shdf_pkg.
module shdf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  shdf_pkg::queue_entry_type  push_entry,
   output logic                       full,
   input  logic                       pop,
   output logic                       empty,
   output shdf_pkg::queue_entry_type  head
);
   import shdf_pkg::*;

   localparam logic [QUEUE_PTR_W-1:0] LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

   queue_entry_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]        wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]        wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]        rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]        rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]        count_ff;
   logic [QUEUE_CNT_W-1:0]        count_in;

   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end
endmodule

// File: rtl/shdf_engine.sv
// Frame engine: sync, header, payload and tail tracking per byte, with the
// registered result stage. Depends on shdf_pkg, shdf_rsp_if, assert_macros.svh.
`include "assert_macros.svh"

module shdf_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  shdf_pkg::cfg_type          cfg,
   input  logic                       empty,
   input  shdf_pkg::queue_entry_type  head,
   output logic                       pop,
   shdf_rsp_if.source                 rsp_chan
);
   import shdf_pkg::*;

   phase_type                 phase_ff;
   phase_type                 phase_in;
   logic [POS_W-1:0]          pos_ff;
   logic [POS_W-1:0]          pos_in;
   logic [HDR_STORE_W-1:0]    hdr_ff;
   logic [HDR_STORE_W-1:0]    hdr_in;
   logic [HALF_W-1:0]         len_ff;
   logic [HALF_W-1:0]         len_in;
   logic [HALF_W-1:0]         sum_ff;
   logic [HALF_W-1:0]         sum_in;
   logic [HALF_W-1:0]         chk_ff;
   logic [HALF_W-1:0]         chk_in;
   logic [TAIL_CNT_W-1:0]     tail_ff;
   logic [TAIL_CNT_W-1:0]     tail_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   result_type                result_ff;
   result_type                result_in;

   logic [BYTE_W-1:0]         ctl;
   logic                      check_on;
   logic                      cipher_on;
   logic [POS_W-1:0]          pos_next;
   logic [POS_W-1:0]          total;
   logic [HALF_W-1:0]         sum_add;
   logic                      last_tail;
   status_type                status;
   logic [BYTE_W-1:0]         pay;
   logic [HALF_W-1:0]         consumed;
   logic                      frame_done;
   logic                      pos_in_header;

   assign pop = !empty && (!rsp_valid_ff || rsp_chan.ready);

   assign ctl       = hdr_ff[HDR_STORE_W-BYTE_W-1 -: BYTE_W];
   assign check_on  = ctl[CHECK_BIT];
   assign cipher_on = (ctl[CIPHER_MSB:CIPHER_LSB] == CIPHER_XOR);
   assign pos_next  = pos_ff + 1'b1;
   assign sum_add   = sum_ff + HALF_W'(head.rx_byte);
   assign total     = POS_W'(TRAILER_BASE) + POS_W'({len_ff[BYTE_W-1:0], head.rx_byte})
                      + (check_on ? POS_W'(CHECK_EXTRA) : '0);
   assign last_tail = check_on ? (tail_ff == 2'd3) : (tail_ff == 2'd1);

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      hdr_in   = hdr_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      chk_in   = chk_ff;
      tail_in  = tail_ff;
      status   = ST_HEADER;
      pay      = '0;
      consumed = pos_ff[HALF_W-1:0];
      if (pop) begin
         unique case (phase_ff)
            PH_HUNT_SECOND: begin
               consumed = HALF_W'(2);
               if (head.second_hit) begin
                  sum_in   = sum_add;
                  pos_in   = POS_W'(2);
                  phase_in = PH_HEADER;
               end else begin
                  status   = ST_BAD_SYNC;
                  pos_in   = '0;
                  phase_in = PH_HUNT_FIRST;
               end
            end
            PH_HEADER: begin
               if (pos_ff < POS_W'(LEN_POS)) begin
                  hdr_in = {hdr_ff[HDR_STORE_W-BYTE_W-1:0], head.rx_byte};
               end else begin
                  len_in = {len_ff[BYTE_W-1:0], head.rx_byte};
               end
               sum_in   = sum_add;
               pos_in   = pos_next;
               consumed = pos_next[HALF_W-1:0];
               if (pos_next >= POS_W'(HDR_LEN)) begin
                  tail_in = '0;
                  if (total >= POS_W'(cfg.frame_limit)) begin
                     status   = ST_OVERSIZE;
                     phase_in = PH_HUNT_FIRST;
                     pos_in   = '0;
                  end else begin
                     phase_in = (len_in != '0) ? PH_PAYLOAD : PH_TAIL;
                  end
               end
            end
            PH_PAYLOAD: begin
               sum_in   = sum_add;
               pay      = cipher_on ? head.descrambled : head.rx_byte;
               status   = ST_PAYLOAD;
               pos_in   = pos_next;
               consumed = pos_next[HALF_W-1:0];
               if (pos_next >= POS_W'(HDR_LEN) + POS_W'(len_ff)) begin
                  phase_in = PH_TAIL;
               end
            end
            PH_TAIL: begin
               if (check_on && !tail_ff[1]) begin
                  chk_in = {chk_ff[BYTE_W-1:0], head.rx_byte};
               end
               pos_in   = pos_next;
               consumed = pos_next[HALF_W-1:0];
               tail_in  = tail_ff + 1'b1;
               if (last_tail) begin
                  status   = (check_on && (chk_in != sum_ff)) ? ST_MISMATCH : ST_ACCEPTED;
                  phase_in = PH_HUNT_FIRST;
                  pos_in   = '0;
               end else begin
                  status = ST_TAIL;
               end
            end
            default: begin
               hdr_in   = '0;
               len_in   = '0;
               chk_in   = '0;
               tail_in  = '0;
               consumed = HALF_W'(1);
               if (head.first_hit) begin
                  sum_in   = HALF_W'(head.rx_byte);
                  pos_in   = POS_W'(1);
                  phase_in = PH_HUNT_SECOND;
               end else begin
                  sum_in   = '0;
                  pos_in   = '0;
                  status   = ST_BAD_SYNC;
                  phase_in = PH_HUNT_FIRST;
               end
            end
         endcase
      end
   end

   always_comb begin
      result_in.status          = status;
      result_in.payload_byte    = pay;
      result_in.version         = hdr_in[HDR_STORE_W-1 -: BYTE_W];
      result_in.frame_control   = hdr_in[HDR_STORE_W-BYTE_W-1 -: BYTE_W];
      result_in.sequence_number = hdr_in[WORD_W+HALF_W-1:WORD_W];
      result_in.time_stamp      = hdr_in[WORD_W-1:0];
      result_in.payload_length  = len_in;
      result_in.frame_length    = consumed;
      result_in.received_check  = chk_in;
      result_in.computed_check  = sum_in;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      hdr_ff  <= hdr_in;
      len_ff  <= len_in;
      sum_ff  <= sum_in;
      chk_ff  <= chk_in;
      tail_ff <= tail_in;
      if (pop) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = result_ff.status;
   assign rsp_chan.payload_byte    = result_ff.payload_byte;
   assign rsp_chan.version         = result_ff.version;
   assign rsp_chan.frame_control   = result_ff.frame_control;
   assign rsp_chan.sequence_number = result_ff.sequence_number;
   assign rsp_chan.time_stamp      = result_ff.time_stamp;
   assign rsp_chan.payload_length  = result_ff.payload_length;
   assign rsp_chan.frame_length    = result_ff.frame_length;
   assign rsp_chan.received_check  = result_ff.received_check;
   assign rsp_chan.computed_check  = result_ff.computed_check;

   assign frame_done    = pop && (status inside {ST_ACCEPTED, ST_MISMATCH, ST_OVERSIZE});
   assign pos_in_header = (pos_ff >= POS_W'(2)) && (pos_ff < POS_W'(HDR_LEN));

   `SHDF_ASSERT(a_end_restarts_hunt, clock, reset, frame_done |=> phase_ff == PH_HUNT_FIRST)
   `SHDF_ASSERT_NEVER(a_payload_has_length, clock, reset, phase_ff == PH_PAYLOAD && len_ff == '0)
   `SHDF_ASSERT(a_header_position, clock, reset, phase_ff == PH_HEADER |-> pos_in_header)
endmodule

// File: bench/sync_header_frame_deframer_test.sv
// Self-checking bench for sync_header_frame_deframer: drives received bytes,
// predicts every result transaction and compares it field by field.
// Depends on shdf_pkg, shdf_req_if, shdf_rsp_if and the deframer RTL.
module sync_header_frame_deframer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import shdf_pkg::*;

   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int REPORT_CAP      = 200;
   localparam int DIRECTED_COUNT  = 31;

   typedef struct packed {
      logic [BYTE_W-1:0] rx;
      logic              typed;
      status_type        status;
      logic [HALF_W-1:0] flen;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   shdf_req_if req_chan ();
   shdf_rsp_if rsp_chan ();

   sync_header_frame_deframer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #4 clock = ~clock;

   // typed expectation travels with the byte on the channel
   logic              typed_on;
   status_type        typed_status;
   logic [HALF_W-1:0] typed_len;

   int send_idle_pct;
   int stall_pct;
   int mismatch_count;
   int result_index;

   logic [BYTE_W-1:0] cur_sync_first  = SYNC_FIRST_RESET;
   logic [BYTE_W-1:0] cur_sync_second = SYNC_SECOND_RESET;
   logic [BYTE_W-1:0] cur_key         = KEY_RESET;
   logic [HALF_W-1:0] cur_limit       = LIMIT_RESET;

   phase_type              deframe_phase = PH_HUNT_FIRST;
   logic [POS_W-1:0]       frame_pos     = '0;
   logic [HDR_STORE_W-1:0] header_bits   = '0;
   logic [HALF_W-1:0]      length_bits   = '0;
   logic [HALF_W-1:0]      byte_sum      = '0;
   logic [HALF_W-1:0]      check_bits    = '0;

   result_type        pending_results[$];
   logic [BYTE_W-1:0] frame_bytes[$];
   logic [HALF_W-1:0] frame_sum;

   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{8'h00, 1'b1, ST_BAD_SYNC, 16'd1},
      '{8'hAA, 1'b0, ST_HEADER,   16'd0},
      '{8'hFF, 1'b1, ST_BAD_SYNC, 16'd2},
      '{8'hAA, 1'b0, ST_HEADER,   16'd0},
      '{8'h55, 1'b0, ST_HEADER,   16'd0},
      '{8'hFF, 1'b0, ST_HEADER,   16'd0},
      '{8'h00, 1'b0, ST_HEADER,   16'd0},
      '{8'hFF, 1'b0, ST_HEADER,   16'd0},
      '{8'hFF, 1'b0, ST_HEADER,   16'd0},
      '{8'hFF, 1'b0, ST_HEADER,   16'd0},
      '{8'hFF, 1'b0, ST_HEADER,   16'd0},
      '{8'hFF, 1'b0, ST_HEADER,   16'd0},
      '{8'hFF, 1'b0, ST_HEADER,   16'd0},
      '{8'hFF, 1'b0, ST_HEADER,   16'd0},
      '{8'hFF, 1'b1, ST_OVERSIZE, 16'd12},
      '{8'hAA, 1'b0, ST_HEADER,   16'd0},
      '{8'h55, 1'b0, ST_HEADER,   16'd0},
      '{8'h00, 1'b0, ST_HEADER,   16'd0},
      '{8'h80, 1'b0, ST_HEADER,   16'd0},
      '{8'h00, 1'b0, ST_HEADER,   16'd0},
      '{8'h00, 1'b0, ST_HEADER,   16'd0},
      '{8'h00, 1'b0, ST_HEADER,   16'd0},
      '{8'h00, 1'b0, ST_HEADER,   16'd0},
      '{8'h00, 1'b0, ST_HEADER,   16'd0},
      '{8'h00, 1'b0, ST_HEADER,   16'd0},
      '{8'h00, 1'b0, ST_HEADER,   16'd0},
      '{8'h00, 1'b0, ST_HEADER,   16'd0},
      '{8'hFF, 1'b0, ST_HEADER,   16'd0},
      '{8'hFF, 1'b0, ST_HEADER,   16'd0},
      '{8'h00, 1'b0, ST_HEADER,   16'd0},
      '{8'h00, 1'b1, ST_MISMATCH, 16'd16}
   };

   function automatic result_type deframe_byte(input logic [BYTE_W-1:0] b);
      result_type r;
      logic [BYTE_W-1:0] ctl;
      int total;
      int tail_pos;
      r = '0;
      ctl = header_bits[55:48];
      case (deframe_phase)
         PH_HUNT_SECOND: begin
            r.frame_length = 16'd2;
            if (b == cur_sync_second) begin
               byte_sum += b;
               frame_pos = 2;
               deframe_phase = PH_HEADER;
            end else begin
               r.status = ST_BAD_SYNC;
               frame_pos = 0;
               deframe_phase = PH_HUNT_FIRST;
            end
         end
         PH_HEADER: begin
            if (frame_pos < LEN_POS) header_bits = {header_bits[55:0], b};
            else length_bits = {length_bits[7:0], b};
            byte_sum += b;
            frame_pos++;
            r.frame_length = frame_pos[15:0];
            if (frame_pos >= HDR_LEN) begin
               ctl = header_bits[55:48];
               total = TRAILER_BASE + int'(length_bits) + (ctl[CHECK_BIT] ? CHECK_EXTRA : 0);
               if (total >= int'(cur_limit)) begin
                  r.status = ST_OVERSIZE;
                  deframe_phase = PH_HUNT_FIRST;
                  frame_pos = 0;
               end else begin
                  deframe_phase = (length_bits != 0) ? PH_PAYLOAD : PH_TAIL;
               end
            end
         end
         PH_PAYLOAD: begin
            byte_sum += b;
            r.payload_byte = (ctl[CIPHER_MSB:CIPHER_LSB] == CIPHER_XOR) ? (b ^ cur_key) : b;
            r.status = ST_PAYLOAD;
            frame_pos++;
            r.frame_length = frame_pos[15:0];
            if (int'(frame_pos) >= HDR_LEN + int'(length_bits)) deframe_phase = PH_TAIL;
         end
         PH_TAIL: begin
            tail_pos = int'(frame_pos) - (HDR_LEN + int'(length_bits));
            if (ctl[CHECK_BIT] && tail_pos < 2) check_bits = {check_bits[7:0], b};
            frame_pos++;
            r.frame_length = frame_pos[15:0];
            if (tail_pos + 1 >= (ctl[CHECK_BIT] ? 4 : 2)) begin
               r.status = (ctl[CHECK_BIT] && check_bits != byte_sum) ? ST_MISMATCH : ST_ACCEPTED;
               deframe_phase = PH_HUNT_FIRST;
               frame_pos = 0;
            end else begin
               r.status = ST_TAIL;
            end
         end
         default: begin
            header_bits = '0;
            length_bits = '0;
            byte_sum = '0;
            check_bits = '0;
            frame_pos = 0;
            r.frame_length = 16'd1;
            if (b == cur_sync_first) begin
               byte_sum = {8'h00, b};
               frame_pos = 1;
               deframe_phase = PH_HUNT_SECOND;
            end else begin
               r.status = ST_BAD_SYNC;
               deframe_phase = PH_HUNT_FIRST;
            end
         end
      endcase
      r.version         = header_bits[63:56];
      r.frame_control   = header_bits[55:48];
      r.sequence_number = header_bits[47:32];
      r.time_stamp      = header_bits[31:0];
      r.payload_length  = length_bits;
      r.received_check  = check_bits;
      r.computed_check  = byte_sum;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_CAP) $display("ERROR transaction %0d: %s", result_index, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   always @(posedge clock) begin : scoreboard
      result_type want;
      result_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            want = deframe_byte(req_chan.rx_byte);
            if (typed_on) begin
               want.status = typed_status;
               want.frame_length = typed_len;
            end
            pending_results.push_back(want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.status, rsp_chan.payload_byte, rsp_chan.version,
                   rsp_chan.frame_control, rsp_chan.sequence_number, rsp_chan.time_stamp,
                   rsp_chan.payload_length, rsp_chan.frame_length, rsp_chan.received_check,
                   rsp_chan.computed_check};
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               want = pending_results.pop_front();
               compare_field("status", got.status, want.status);
               compare_field("payload_byte", got.payload_byte, want.payload_byte);
               compare_field("version", got.version, want.version);
               compare_field("frame_control", got.frame_control, want.frame_control);
               compare_field("sequence_number", got.sequence_number, want.sequence_number);
               compare_field("time_stamp", got.time_stamp, want.time_stamp);
               compare_field("payload_length", got.payload_length, want.payload_length);
               compare_field("frame_length", got.frame_length, want.frame_length);
               compare_field("received_check", got.received_check, want.received_check);
               compare_field("computed_check", got.computed_check, want.computed_check);
            end
            result_index++;
         end
      end
   end

   initial begin : receiver
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [BYTE_W-1:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic void add_byte(input logic [BYTE_W-1:0] b);
      frame_bytes.push_back(b);
      frame_sum += b;
   endfunction

   task automatic build_frame();
      int pick;
      int len_val;
      int base;
      int cut;
      logic [BYTE_W-1:0] ctl;
      logic [HALF_W-1:0] chk;
      frame_bytes.delete();
      frame_sum = '0;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         repeat ($urandom_range(1, 4)) frame_bytes.push_back(rand_byte());
      end else if (pick < 18) begin
         frame_bytes.push_back(cur_sync_first);
         frame_bytes.push_back(cur_sync_second ^ (8'd1 << $urandom_range(0, 7)));
      end else begin
         ctl = rand_byte();
         base = TRAILER_BASE + (ctl[CHECK_BIT] ? CHECK_EXTRA : 0);
         if (pick < 28) begin
            len_val = $urandom_range((int'(cur_limit) > base) ? int'(cur_limit) - base : 0, 65535);
         end else begin
            cut = $urandom_range(0, 99);
            if (cut < 15) len_val = 0;
            else if (cut < 78) len_val = $urandom_range(1, 12);
            else if (cut < 90) len_val = $urandom_range(13, 48);
            else begin
               // land just below or exactly on the size limit
               len_val = int'(cur_limit) - $urandom_range(0, 1) - base;
               if (len_val < 0) len_val = 0;
               if (len_val > 64) len_val = int'(cur_limit) - base;
            end
         end
         add_byte(cur_sync_first);
         add_byte(cur_sync_second);
         add_byte(rand_byte());
         add_byte(ctl);
         repeat (6) add_byte(rand_byte());
         add_byte(len_val[15:8]);
         add_byte(len_val[7:0]);
         if (base + len_val < int'(cur_limit)) begin
            repeat (len_val) add_byte(rand_byte());
            if (ctl[CHECK_BIT]) begin
               chk = ($urandom_range(0, 3) != 0) ? frame_sum : 16'($urandom);
               frame_bytes.push_back(chk[15:8]);
               frame_bytes.push_back(chk[7:0]);
            end
            frame_bytes.push_back(rand_byte());
            frame_bytes.push_back(rand_byte());
         end
         if (pick >= 93) begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         end
      end
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                            input status_type st, input logic [HALF_W-1:0] flen);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      typed_on         <= typed;
      typed_status     <= st;
      typed_len        <= flen;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         CSR_SYNC_FIRST:   cur_sync_first  = value[7:0];
         CSR_SYNC_SECOND:  cur_sync_second = value[7:0];
         CSR_SCRAMBLE_KEY: cur_key         = value[7:0];
         default:          cur_limit       = value;
      endcase
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int sent;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.rx_byte <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= CSR_SYNC_FIRST;
      csr_write_data <= '0;
      typed_on       <= 1'b0;
      typed_status   <= ST_HEADER;
      typed_len      <= '0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      mismatch_count = 0;
      result_index   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
         if (phase_idx > 0) begin
            wait_drained();
            if (phase_idx == 1) begin
               write_reg(CSR_SYNC_FIRST, 16'h0000);
               write_reg(CSR_SYNC_SECOND, 16'h0000);
               write_reg(CSR_SCRAMBLE_KEY, 16'h0000);
               write_reg(CSR_FRAME_LIMIT, 16'd16);
            end else if (phase_idx == 2) begin
               write_reg(CSR_SYNC_FIRST, 16'h00FF);
               write_reg(CSR_SYNC_SECOND, 16'h00FF);
               write_reg(CSR_SCRAMBLE_KEY, 16'h00FF);
               write_reg(CSR_FRAME_LIMIT, 16'hFFFF);
            end else begin
               write_reg(CSR_SYNC_FIRST, 16'($urandom));
               write_reg(CSR_SYNC_SECOND, 16'($urandom));
               write_reg(CSR_SCRAMBLE_KEY, 16'($urandom));
               write_reg(CSR_FRAME_LIMIT, $urandom_range(0, 1) ?
                         16'($urandom_range(16, 120)) : 16'($urandom_range(121, 65535)));
            end
            csr_write_en <= 1'b0;
         end
         case (phase_idx % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 80; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 80; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
         endcase
         if (phase_idx == 0) begin
            foreach (directed_rows[i])
               send_byte(directed_rows[i].rx, directed_rows[i].typed,
                         directed_rows[i].status, directed_rows[i].flen);
         end
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            build_frame();
            foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, ST_HEADER, 16'd0);
            sent += frame_bytes.size();
         end
         req_chan.valid <= 1'b0;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
